/* rtl/tmgf_pkg.sv */
// shared types and constants of the touch median gesture filter
package tmgf_pkg;

    localparam int unsigned COORD_W    = 16;
    localparam int unsigned PICK_INDEX = 3;
    localparam logic [COORD_W-1:0] NO_TOUCH = 16'h8000;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_MOVE    = 2'd1,
        EV_RELEASE = 2'd2
    } t_event_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_CHECK,
        S_CP_RD,
        S_CP_WR,
        S_PICK,
        S_PICK_X,
        S_PICK_Y,
        S_EVAL,
        S_DIFF_Y,
        S_EMIT
    } t_state;

endpackage

/* rtl/tmgf_ram.sv */
// generic single write port, single read port ram with registered read
module tmgf_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/touch_median_gesture_filter_top.sv */
// touch median gesture filter: sorted coordinate stores, trim and event generation
// one word at a time: the input stalls until the sequencer is back in idle, also while
//   an event waits on an output stall; each moved ram entry costs a read and a write
// reset: synchronous active low; stores empty, no press pending, position, movement and
//   output valid cleared, move threshold 1
module touch_median_gesture_filter_top #(
    parameter int unsigned STORE_DEPTH   = 16,
    parameter int unsigned WINDOW_LIMIT  = 12,
    parameter int unsigned TRIM_EACH_END = 3
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [7:0]                     i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_func,
    input  logic [tmgf_pkg::COORD_W-1:0]   i_x_coord,
    input  logic [tmgf_pkg::COORD_W-1:0]   i_y_coord,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [1:0]                     o_event_kind,
    output logic [tmgf_pkg::COORD_W-1:0]   o_pos_x,
    output logic [tmgf_pkg::COORD_W-1:0]   o_pos_y,
    output logic [tmgf_pkg::COORD_W-1:0]   o_delta_x,
    output logic [tmgf_pkg::COORD_W-1:0]   o_delta_y
);

    import tmgf_pkg::*;

    localparam int unsigned AW        = $clog2(STORE_DEPTH);
    localparam int unsigned CW        = $clog2(STORE_DEPTH + 1);
    localparam int unsigned XW        = CW + 2;
    localparam int unsigned RAM_DEPTH = 2 ** (AW + 1);

    localparam logic [CW-1:0] FILL_FULL = CW'(STORE_DEPTH);
    localparam logic [XW-1:0] WIN_X     = XW'(WINDOW_LIMIT);
    localparam logic [XW-1:0] TRIM2_X   = XW'(2 * TRIM_EACH_END);
    localparam logic [XW-1:0] PICK_X    = XW'(PICK_INDEX);
    localparam logic [AW:0]   TRIM_A    = (AW + 1)'(TRIM_EACH_END);
    localparam logic [AW-1:0] PICK_A    = AW'(PICK_INDEX);

    t_state r_state, n_state;

    // control state
    logic [CW-1:0]      r_fill, n_fill;
    logic               r_pend, n_pend;
    logic [COORD_W-1:0] r_last_x, n_last_x, r_last_y, n_last_y;
    logic [COORD_W-1:0] r_move_x, n_move_x, r_move_y, n_move_y;
    logic [7:0]         r_thr;
    logic               r_out_valid, n_out_valid;

    // sequencer and payload
    logic [AW-1:0]      r_idx, n_idx;
    logic               r_axis, n_axis;
    logic               r_func;
    logic [COORD_W-1:0] r_x, r_y;
    logic [COORD_W-1:0] r_nx, n_nx, r_ny, n_ny;
    logic               r_over_x, n_over_x;
    logic [COORD_W-1:0] r_dx, n_dx;
    t_event_kind        r_kind, n_kind;
    t_event_kind        r_out_kind;
    logic [COORD_W-1:0] r_out_pos_x, r_out_pos_y, r_out_dx, r_out_dy;
    logic               ld_out;

    // coordinate ram: x entries in the lower half, y in the upper half
    logic               ram_we;
    logic [AW:0]        ram_waddr, ram_raddr;
    logic [COORD_W-1:0] ram_wdata, ram_rdata;

    logic               in_acc;
    logic [COORD_W-1:0] ins_val;
    logic [XW-1:0]      fill_x;
    logic [AW:0]        cp_src;

    // shared subtractor for the movement test
    logic [COORD_W-1:0] sub_a, sub_b;
    logic [COORD_W:0]   diff, diff_abs;
    logic               over;

    tmgf_ram #(
        .WIDTH(COORD_W),
        .DEPTH(RAM_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign in_acc  = i_in_valid && !o_in_stall;
    assign ins_val = r_axis ? r_y : r_x;
    assign fill_x  = XW'(r_fill);
    assign cp_src  = (AW + 1)'(r_idx) + TRIM_A;

    assign sub_a    = (r_state == S_DIFF_Y) ? r_ny : r_nx;
    assign sub_b    = (r_state == S_DIFF_Y) ? r_last_y : r_last_x;
    assign diff     = {sub_a[COORD_W-1], sub_a} - {sub_b[COORD_W-1], sub_b};
    assign diff_abs = diff[COORD_W] ? (~diff + 1'b1) : diff;
    assign over     = diff_abs > (COORD_W + 1)'(r_thr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_pend      = r_pend;
        n_last_x    = r_last_x;
        n_last_y    = r_last_y;
        n_move_x    = r_move_x;
        n_move_y    = r_move_y;
        n_out_valid = r_out_valid && i_out_stall;
        n_idx       = r_idx;
        n_axis      = r_axis;
        n_nx        = r_nx;
        n_ny        = r_ny;
        n_over_x    = r_over_x;
        n_dx        = r_dx;
        n_kind      = r_kind;
        ld_out      = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = {r_axis, r_idx};
        ram_wdata   = ins_val;
        ram_raddr   = {r_axis, r_idx - AW'(1)};

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (!i_func) begin
                        n_pend = 1'b1;
                    end
                    if (i_func && i_x_coord == NO_TOUCH && i_y_coord == NO_TOUCH) begin
                        n_kind  = EV_RELEASE;
                        n_state = S_EMIT;
                    end else if (r_fill == FILL_FULL) begin
                        n_state = S_CHECK;
                    end else begin
                        n_axis  = 1'b0;
                        n_idx   = r_fill[AW-1:0];
                        n_state = S_INS_RD;
                    end
                end
            end
            S_INS_RD: begin
                if (r_idx == '0) begin
                    ram_we = 1'b1;
                    if (!r_axis) begin
                        n_axis  = 1'b1;
                        n_idx   = r_fill[AW-1:0];
                        n_state = S_INS_RD;
                    end else begin
                        n_fill  = r_fill + CW'(1);
                        n_state = S_CHECK;
                    end
                end else begin
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                ram_we = 1'b1;
                if ($signed(ram_rdata) > $signed(ins_val)) begin
                    // shift the larger entry up one place
                    ram_wdata = ram_rdata;
                    n_idx     = r_idx - AW'(1);
                    n_state   = S_INS_RD;
                end else if (!r_axis) begin
                    n_axis  = 1'b1;
                    n_idx   = r_fill[AW-1:0];
                    n_state = S_INS_RD;
                end else begin
                    n_fill  = r_fill + CW'(1);
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!r_func || fill_x <= WIN_X) begin
                    n_state = S_IDLE;
                end else if (fill_x <= TRIM2_X) begin
                    n_fill  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_fill  = CW'(fill_x - TRIM2_X);
                    n_axis  = 1'b0;
                    n_idx   = '0;
                    n_state = S_CP_RD;
                end
            end
            S_CP_RD: begin
                ram_raddr = {r_axis, cp_src[AW-1:0]};
                n_state   = S_CP_WR;
            end
            S_CP_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                if (CW'(r_idx) + CW'(1) == r_fill) begin
                    if (!r_axis) begin
                        n_axis  = 1'b1;
                        n_idx   = '0;
                        n_state = S_CP_RD;
                    end else begin
                        n_state = S_PICK;
                    end
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_CP_RD;
                end
            end
            S_PICK: begin
                ram_raddr = {1'b0, PICK_A};
                if (fill_x <= PICK_X) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_PICK_X;
                end
            end
            S_PICK_X: begin
                n_nx      = ram_rdata;
                ram_raddr = {1'b1, PICK_A};
                n_state   = S_PICK_Y;
            end
            S_PICK_Y: begin
                n_ny    = ram_rdata;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (r_pend) begin
                    n_pend   = 1'b0;
                    n_last_x = r_nx;
                    n_last_y = r_ny;
                    n_kind   = EV_PRESS;
                    n_state  = S_EMIT;
                end else begin
                    n_over_x = over;
                    n_dx     = diff[COORD_W-1:0];
                    n_state  = S_DIFF_Y;
                end
            end
            S_DIFF_Y: begin
                if (r_over_x || over) begin
                    n_move_x = r_dx;
                    n_move_y = diff[COORD_W-1:0];
                    n_last_x = r_nx;
                    n_last_y = r_ny;
                    n_kind   = EV_MOVE;
                    n_state  = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    ld_out      = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_kind == EV_RELEASE) begin
                        n_fill   = '0;
                        n_last_x = '0;
                        n_last_y = '0;
                        n_move_x = '0;
                        n_move_y = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_move_x    <= '0;
            r_move_y    <= '0;
            r_thr       <= 8'd1;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_pend      <= n_pend;
            r_last_x    <= n_last_x;
            r_last_y    <= n_last_y;
            r_move_x    <= n_move_x;
            r_move_y    <= n_move_y;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_axis   <= n_axis;
        r_nx     <= n_nx;
        r_ny     <= n_ny;
        r_over_x <= n_over_x;
        r_dx     <= n_dx;
        r_kind   <= n_kind;
        if (in_acc) begin
            r_func <= i_func;
            r_x    <= i_x_coord;
            r_y    <= i_y_coord;
        end
        if (ld_out) begin
            r_out_kind  <= r_kind;
            r_out_pos_x <= r_last_x;
            r_out_pos_y <= r_last_y;
            // a press carries no movement
            r_out_dx    <= (r_kind == EV_PRESS) ? '0 : r_move_x;
            r_out_dy    <= (r_kind == EV_PRESS) ? '0 : r_move_y;
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_event_kind = r_out_kind;
    assign o_pos_x      = r_out_pos_x;
    assign o_pos_y      = r_out_pos_y;
    assign o_delta_x    = r_out_dx;
    assign o_delta_y    = r_out_dy;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("fill count beyond store depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("word accepted without the sequencer leaving idle");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_EMIT)
        else $error("output word loaded outside the emit step");

    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_kind == EV_RELEASE && (!r_out_valid || !i_out_stall))
        |=> (r_fill == '0 && r_last_x == '0 && r_last_y == '0 && r_move_x == '0))
        else $error("release did not clear the tracking state");

    a_insert_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_RD || r_state == S_INS_CMP) |-> CW'(r_idx) <= r_fill)
        else $error("insertion index above fill count");

endmodule

/* dv/tmgf_tb_pkg.sv */
// testbench-side codes shared by the gesture filter checker and stimulus
`timescale 1ns / 1ps

package tmgf_tb_pkg;

    localparam logic FUNC_TOUCH   = 1'b0;
    localparam logic FUNC_CONVERT = 1'b1;

endpackage

/* dv/touch_event_checker.sv */
// checker for the gesture filter: predicts events from accepted words and compares them
`timescale 1ns / 1ps

module touch_event_checker #(
    parameter int STORE_DEPTH   = 16,
    parameter int WINDOW_LIMIT  = 12,
    parameter int TRIM_EACH_END = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [7:0]                   i_cfg_wdata,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic                         i_func,
    input  logic [tmgf_pkg::COORD_W-1:0] i_x_coord,
    input  logic [tmgf_pkg::COORD_W-1:0] i_y_coord,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [1:0]                   i_event_kind,
    input  logic [tmgf_pkg::COORD_W-1:0] i_pos_x,
    input  logic [tmgf_pkg::COORD_W-1:0] i_pos_y,
    input  logic [tmgf_pkg::COORD_W-1:0] i_delta_x,
    input  logic [tmgf_pkg::COORD_W-1:0] i_delta_y,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_checked
);

    import tmgf_pkg::*;
    import tmgf_tb_pkg::*;

    localparam int DUE_DEPTH = 16;

    typedef struct packed {
        t_event_kind        kind;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
    } t_touch_event;

    // ring of predicted events still waiting for the output side
    t_touch_event due_buf [DUE_DEPTH];
    int           due_wr;
    int           due_rd;

    logic signed [COORD_W-1:0] x_sorted [STORE_DEPTH];
    logic signed [COORD_W-1:0] y_sorted [STORE_DEPTH];
    int                        fill;
    bit                        press_due;
    logic signed [COORD_W-1:0] last_x, last_y;
    logic signed [COORD_W-1:0] move_x, move_y;
    logic [7:0]                move_thr;

    int fails   = 0;
    int checked = 0;

    assign o_fail_count = fails;
    assign o_checked    = checked;

    task automatic add_due(input t_touch_event ev);
        due_buf[due_wr % DUE_DEPTH] = ev;
        due_wr++;
    endtask

    task automatic insert_sample(input logic signed [COORD_W-1:0] x,
                                 input logic signed [COORD_W-1:0] y);
        int i;
        if (fill >= STORE_DEPTH) return;
        i = fill;
        while (i > 0 && x_sorted[i-1] > x) begin
            x_sorted[i] = x_sorted[i-1];
            i--;
        end
        x_sorted[i] = x;
        i = fill;
        while (i > 0 && y_sorted[i-1] > y) begin
            y_sorted[i] = y_sorted[i-1];
            i--;
        end
        y_sorted[i] = y;
        fill++;
    endtask

    // works out the event, if any, that one accepted word causes
    task automatic apply_word(input logic f,
                              input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y);
        t_touch_event ev;
        int k;
        int dxf, dyf;
        logic signed [COORD_W-1:0] nx, ny;
        if (f == FUNC_TOUCH) begin
            insert_sample(x, y);
            press_due = 1'b1;
            return;
        end
        if (x == NO_TOUCH && y == NO_TOUCH) begin
            ev = '{kind: EV_RELEASE, px: last_x, py: last_y, dx: move_x, dy: move_y};
            add_due(ev);
            fill   = 0;
            last_x = '0;
            last_y = '0;
            move_x = '0;
            move_y = '0;
            return;
        end
        insert_sample(x, y);
        if (fill <= WINDOW_LIMIT) return;
        // drop the outliers at both ends of each axis
        if (fill <= 2 * TRIM_EACH_END) begin
            fill = 0;
        end else begin
            for (k = 0; k < fill - 2 * TRIM_EACH_END; k++) begin
                x_sorted[k] = x_sorted[k + TRIM_EACH_END];
                y_sorted[k] = y_sorted[k + TRIM_EACH_END];
            end
            fill = fill - 2 * TRIM_EACH_END;
        end
        if (fill <= PICK_INDEX) return;
        nx = x_sorted[PICK_INDEX];
        ny = y_sorted[PICK_INDEX];
        if (press_due) begin
            last_x    = nx;
            last_y    = ny;
            press_due = 1'b0;
            ev = '{kind: EV_PRESS, px: nx, py: ny, dx: '0, dy: '0};
            add_due(ev);
            return;
        end
        // threshold test on the unwrapped difference
        dxf = int'(nx) - int'(last_x);
        dyf = int'(ny) - int'(last_y);
        if ((dxf < 0 ? -dxf : dxf) > int'(move_thr) ||
            (dyf < 0 ? -dyf : dyf) > int'(move_thr)) begin
            move_x = dxf[COORD_W-1:0];
            move_y = dyf[COORD_W-1:0];
            last_x = nx;
            last_y = ny;
            ev = '{kind: EV_MOVE, px: nx, py: ny, dx: move_x, dy: move_y};
            add_due(ev);
        end
    endtask

    task automatic check_field(input string what, input logic [COORD_W-1:0] want,
                               input logic [COORD_W-1:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_touch_event want;
        if (!i_rst_n) begin
            due_wr    = 0;
            due_rd    = 0;
            fill      = 0;
            press_due = 1'b0;
            last_x    = '0;
            last_y    = '0;
            move_x    = '0;
            move_y    = '0;
            move_thr  = 8'd1;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (due_wr == due_rd) begin
                    fails++;
                    $display("%0t: unexpected event, expected none, got kind %0d pos %h %h",
                             $time, i_event_kind, i_pos_x, i_pos_y);
                end else begin
                    want = due_buf[due_rd % DUE_DEPTH];
                    due_rd++;
                    checked++;
                    check_field("event_kind", {14'd0, want.kind}, {14'd0, i_event_kind});
                    check_field("pos_x", want.px, i_pos_x);
                    check_field("pos_y", want.py, i_pos_y);
                    check_field("delta_x", want.dx, i_delta_x);
                    check_field("delta_y", want.dy, i_delta_y);
                end
            end
            if (i_cfg_we)
                move_thr = i_cfg_wdata;
            if (i_in_valid && !i_in_stall)
                apply_word(i_func, i_x_coord, i_y_coord);
        end
        o_pending <= due_wr - due_rd;
    end

endmodule

/* dv/touch_median_gesture_filter_top_tb.sv */
// testbench top for the touch median gesture filter: stimulus, idling and verdict
`timescale 1ns / 1ps

module touch_median_gesture_filter_top_tb;

    import tmgf_pkg::*;
    import tmgf_tb_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 500;
    localparam int SETTLE_GAP   = 150;
    localparam int PHASES       = 6;
    localparam int PHASE_WORDS  = 230;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [7:0]         i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_func;
    logic [COORD_W-1:0] i_x_coord;
    logic [COORD_W-1:0] i_y_coord;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [1:0]         o_event_kind;
    logic [COORD_W-1:0] o_pos_x;
    logic [COORD_W-1:0] o_pos_y;
    logic [COORD_W-1:0] o_delta_x;
    logic [COORD_W-1:0] o_delta_y;

    int fails;
    int pending;
    int checked;

    int words_sent  = 0;
    int quiet_count = 0;
    bit tx_eager    = 1'b0;
    bit rx_eager    = 1'b0;
    int hold_req    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;

    always #5 i_clk = ~i_clk;

    touch_median_gesture_filter_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_x_coord    (i_x_coord),
        .i_y_coord    (i_y_coord),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_event_kind (o_event_kind),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_delta_x    (o_delta_x),
        .o_delta_y    (o_delta_y)
    );

    touch_event_checker event_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_x_coord    (i_x_coord),
        .i_y_coord    (i_y_coord),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_event_kind (o_event_kind),
        .i_pos_x      (o_pos_x),
        .i_pos_y      (o_pos_y),
        .i_delta_x    (o_delta_x),
        .i_delta_y    (o_delta_y),
        .o_fail_count (fails),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // receiver: random stalls, a quiet stretch, and one long hold on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_req != hold_seen) begin
            hold_seen   <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (rx_eager) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < 17);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= QUIET_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_count);
            $display("touch_median_gesture_filter_top_tb: errors");
            $finish;
        end
    end

    function automatic logic [COORD_W-1:0] clip16(input int v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[COORD_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] rand16();
        return COORD_W'($urandom_range(0, 65535));
    endfunction

    task automatic send_word(input logic f, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y);
        if (!tx_eager) begin
            while ($urandom_range(0, 99) < 17) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_func     <= f;
        i_x_coord  <= x;
        i_y_coord  <= y;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
    endtask

    // wait for every predicted event, then give the block time to finish silent work
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_GAP) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [7:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // press, a drifting trace with jitter and outliers, then lift; press and lift are each skipped at random
    task automatic run_stroke();
        int cx, cy, step, n;
        case ($urandom_range(0, 3))
            0: step = 1;
            1: step = 30;
            2: step = 400;
            default: step = 5000;
        endcase
        cx = int'($urandom_range(0, 65535)) - 32768;
        cy = int'($urandom_range(0, 65535)) - 32768;
        if ($urandom_range(0, 9) != 0)
            send_word(FUNC_TOUCH, clip16(cx), clip16(cy));
        n = $urandom_range(6, 40);
        repeat (n) begin
            cx = cx + int'($urandom_range(0, 2 * step)) - step;
            cy = cy + int'($urandom_range(0, 2 * step)) - step;
            if ($urandom_range(0, 9) == 0)
                send_word(FUNC_CONVERT, rand16(), rand16());
            else
                send_word(FUNC_CONVERT, clip16(cx + int'($urandom_range(0, 8)) - 4),
                          clip16(cy + int'($urandom_range(0, 8)) - 4));
        end
        if ($urandom_range(0, 9) != 0)
            send_word(FUNC_CONVERT, NO_TOUCH, NO_TOUCH);
    endtask

    task automatic run_noise();
        repeat ($urandom_range(1, 5)) begin
            if ($urandom_range(0, 19) == 0)
                send_word(logic'($urandom_range(0, 1)), NO_TOUCH, NO_TOUCH);
            else
                send_word(logic'($urandom_range(0, 1)), rand16(), rand16());
        end
    endtask

    // a burst of touch words that can fill the store and overflow it, then a conversion
    task automatic run_fill_burst();
        repeat ($urandom_range(14, 20))
            send_word(FUNC_TOUCH, rand16(), rand16());
        send_word(FUNC_CONVERT, rand16(), rand16());
    endtask

    initial begin
        int ph, start, pick;
        bit held;
        logic [7:0] thr_plan [PHASES];
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_func      = FUNC_TOUCH;
        i_x_coord   = '0;
        i_y_coord   = '0;
        held        = 1'b0;
        thr_plan    = '{8'd0, 8'd255, 8'd0, 8'd1, 8'd0, 8'd255};
        thr_plan[2] = 8'($urandom_range(2, 254));
        thr_plan[4] = 8'($urandom_range(0, 255));
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // release straight out of reset, marker stored as a touch, then a press at the
        // corner and a jump across the whole range whose delta wraps
        send_word(FUNC_CONVERT, NO_TOUCH, NO_TOUCH);
        send_word(FUNC_TOUCH, NO_TOUCH, NO_TOUCH);
        repeat (12) send_word(FUNC_CONVERT, 16'h8000, 16'h7fff);
        repeat (12) send_word(FUNC_CONVERT, 16'h7fff, 16'h8000);
        send_word(FUNC_CONVERT, NO_TOUCH, NO_TOUCH);

        for (ph = 0; ph < PHASES; ph++) begin
            settle();
            write_threshold(thr_plan[ph]);
            tx_eager = (ph == 3);
            rx_eager <= (ph == 3);
            start = words_sent;
            while (words_sent - start < PHASE_WORDS) begin
                if (ph == 1 && !held && words_sent - start > 40) begin
                    hold_req <= hold_req + 1;
                    held = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 72)
                    run_stroke();
                else if (pick < 88)
                    run_noise();
                else
                    run_fill_burst();
            end
        end
        settle();

        $display("sent %0d words under %0d threshold settings from 0 to 255", words_sent,
                 PHASES + 1);
        $display("compared %0d events, with a long output hold and a quiet-link stretch",
                 checked);
        if (fails == 0)
            $display("touch_median_gesture_filter_top_tb: clean");
        else
            $display("touch_median_gesture_filter_top_tb: errors");
        $finish;
    end

endmodule
